>>> hdl/cl2n_pkg.sv
// Shared constants and types for the channel L2 normalize and scale block.
package cl2n_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SCALE_W      = 16;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int SUM_W        = 37;
    localparam int SUM_PAD_W    = 38;
    localparam int FRAC_PAIRS   = 8;
    localparam int ROOT_ITERS   = SUM_PAD_W / 2 + FRAC_PAIRS;
    localparam int ROOT_W       = 27;
    localparam int RREM_W       = 28;
    localparam int PROD_W       = 32;
    localparam int DVD_W        = 42;
    localparam int DREM_W       = 28;
    localparam int ITER_W       = 6;
    localparam int WORD_W       = SAMPLE_WIDTH + SCALE_W;

    typedef enum logic [3:0] {
        ST_ACCEPT,
        ST_SQUARE,
        ST_ADD,
        ST_ROOT,
        ST_READ,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> hdl/channel_l2_normalize_scale_top.sv
// Channel L2 normalize and scale top level.
// Each input word carries one channel sample of a spatial position and its scale. The block
// takes a word only after the previous one has been added, storing it and adding its exact square
// to the running sum through a single shared 16x16 multiplier. After the word marked last,
// the square root of the sum is formed by a digit-by-digit root unit. Each stored channel
// then goes through the channel buffer read, one pass through the shared multiplier and a
// 42-step restoring divider, then waits for its result to be taken. Words are not accepted
// while a position is being emitted, and words beyond 64 channels are dropped.
module channel_l2_normalize_scale_top
    import cl2n_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic signed [15:0]      sample,
    input  logic [15:0]             channel_scale,
    input  logic                    last,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic signed [15:0]      normalized,
    output logic [IDX_W-1:0]        channel_index,
    output logic                    final_res
);

    state_t               state_reg, state_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 last_reg, last_next;
    logic                 store_reg, store_next;
    logic                 neg_reg, neg_next;
    logic [15:0]          mag_reg, mag_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SUM_PAD_W-1:0] rsh_reg, rsh_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [RREM_W-1:0]    rrem_reg, rrem_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DREM_W-1:0]    drem_reg, drem_next;

    logic                 ram_we;
    logic [WORD_W-1:0]    ram_rdata;
    logic [15:0]          mul_a, mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [15:0]          in_mag, rd_mag;
    logic [RREM_W+1:0]    rrem_w;
    logic [RREM_W+1:0]    rtrial;
    logic [DREM_W:0]      drem_w;
    logic [DREM_W-1:0]    dsr;
    logic [SUM_W-1:0]     sum_add;
    logic                 is_final;

    cl2n_ram #(.WIDTH(WORD_W), .DEPTH(MAX_CHANNELS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata ({channel_scale, sample}),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign in_mag  = sample[15] ? 16'(-sample) : sample;
    assign rd_mag  = ram_rdata[15] ? 16'(-ram_rdata[15:0]) : ram_rdata[15:0];
    assign mul_a   = (state_reg == ST_MUL) ? rd_mag : mag_reg;
    assign mul_b   = (state_reg == ST_MUL) ? ram_rdata[WORD_W-1:SAMPLE_WIDTH] : mag_reg;
    assign mul_p   = mul_a * mul_b;
    assign sum_add = sum_reg + (store_reg ? SUM_W'(prod_reg) : '0);
    assign rrem_w  = {rrem_reg, rsh_reg[SUM_PAD_W-1 -: 2]};
    assign rtrial  = {1'b0, root_reg, 2'b01};
    assign dsr     = {root_reg, 1'b0};
    assign drem_w  = {drem_reg, dvd_reg[DVD_W-1]};
    assign ram_we  = (state_reg == ST_ACCEPT) && item_valid && (cnt_reg < CNT_W'(MAX_CHANNELS));
    assign is_final = ({1'b0, k_reg} + CNT_W'(1)) == cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            iter_reg  <= '0;
            last_reg  <= 1'b0;
            store_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            iter_reg  <= iter_next;
            last_reg  <= last_next;
            store_reg <= store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        rsh_reg  <= rsh_next;
        root_reg <= root_next;
        rrem_reg <= rrem_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        iter_next  = iter_reg;
        last_next  = last_reg;
        store_next = store_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        prod_next  = prod_reg;
        rsh_next   = rsh_reg;
        root_next  = root_reg;
        rrem_next  = rrem_reg;
        dvd_next   = dvd_reg;
        drem_next  = drem_reg;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (item_valid)
                begin
                    mag_next   = in_mag;
                    last_next  = last;
                    store_next = ram_we;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                prod_next  = mul_p;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                sum_next  = sum_add;
                cnt_next  = cnt_reg + CNT_W'(store_reg);
                rsh_next  = SUM_PAD_W'(sum_add);
                root_next = '0;
                rrem_next = '0;
                iter_next = '0;
                state_next = last_reg ? ST_ROOT : ST_ACCEPT;
            end
            ST_ROOT:
            begin
                rsh_next = {rsh_reg[SUM_PAD_W-3:0], 2'b00};
                if (rrem_w >= rtrial)
                begin
                    rrem_next = RREM_W'(rrem_w - rtrial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rrem_next = RREM_W'(rrem_w);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ROOT_ITERS - 1))
                begin
                    k_next = '0;
                    if (cnt_reg == '0)
                    begin
                        sum_next   = '0;
                        state_next = ST_ACCEPT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                neg_next   = ram_rdata[SAMPLE_WIDTH-1];
                prod_next  = mul_p;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                dvd_next   = {1'b0, prod_reg, 9'b0} + DVD_W'(root_reg);
                drem_next  = '0;
                iter_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (drem_w >= {1'b0, dsr})
                begin
                    drem_next = DREM_W'(drem_w - {1'b0, dsr});
                    dvd_next  = {dvd_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = DREM_W'(drem_w);
                    dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                end
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DVD_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    if (is_final)
                    begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_ACCEPT;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        if (sum_reg == '0)
        begin
            normalized = '0;
        end
        else if (neg_reg)
        begin
            normalized = (|dvd_reg[DVD_W-1:15]) ? 16'sh8000 : 16'(-dvd_reg[15:0]);
        end
        else
        begin
            normalized = (|dvd_reg[DVD_W-1:15]) ? 16'sh7fff : dvd_reg[15:0];
        end
    end

    assign item_ready    = (state_reg == ST_ACCEPT);
    assign res_valid     = (state_reg == ST_OUT);
    assign channel_index = k_reg;
    assign final_res     = is_final;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CHANNELS))
        else $error("Channel count exceeds the channel limit.");

    a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, k_reg} < cnt_reg))
        else $error("Result index is not below the channel count.");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (item_ready && cnt_reg == '0) |-> (sum_reg == '0))
        else $error("Sum of squares is not clear at the start of a position.");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && final_res) |=> (item_ready && cnt_reg == '0))
        else $error("Position state was not cleared after the final result.");

endmodule

>>> hdl/cl2n_ram.sv
// Generic single write port RAM with one registered read port.
module cl2n_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
